// ----- src/serial_text_number_formatter_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SERIAL_TEXT_NUMBER_FORMATTER_CORE_DEFINES_SVH
`define SERIAL_TEXT_NUMBER_FORMATTER_CORE_DEFINES_SVH

// Antecedent in this cycle, consequent in the next.
`define STNF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stnf: next-cycle check failed");

// Antecedent and consequent in the same cycle.
`define STNF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stnf: same-cycle check failed");

`endif

// ----- src/stnf_pkg.sv -----
`timescale 1ns / 1ps

package stnf_pkg;

  localparam int ValueWidthDef = 32;
  localparam int NumBits       = 32;
  localparam int DecMax        = 10;
  localparam int DigW          = $clog2(DecMax);

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiA    = 8'h41;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [1:0] OpText = 2'd0;
  localparam logic [1:0] OpDec  = 2'd1;
  localparam logic [1:0] OpHex  = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
  } bcd_ctl_t;

  typedef logic [DecMax-1:0][3:0] bcd_digits_t;

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    if (v <= 4'd9) begin
      return AsciiZero + {4'b0000, v};
    end
    return AsciiA + {4'b0000, v - 4'hA};
  endfunction

endpackage

// ----- src/stnf_bcd_unit.sv -----
`timescale 1ns / 1ps

module stnf_bcd_unit (
  input  logic                   clk_i,
  input  stnf_pkg::bcd_ctl_t     ctl_i,
  input  logic [31:0]            value_i,
  output stnf_pkg::bcd_digits_t  digits_o
);
  import stnf_pkg::*;

  logic [NumBits-1:0] bin_q, bin_d;
  bcd_digits_t        bcd_q, bcd_d;
  bcd_digits_t        adj;

  // add-3 on every digit, then one shift: one double-dabble step
  always_comb begin
    for (int i = 0; i < DecMax; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    bcd_d = bcd_q;
    bin_d = bin_q;
    if (ctl_i.load) begin
      bcd_d = '0;
      bin_d = value_i[NumBits-1:0];
    end else if (ctl_i.step) begin
      bcd_d = {adj[DecMax-1][2:0], adj[DecMax-2:0], bin_q[NumBits-1]};
      bin_d = {bin_q[NumBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign digits_o = bcd_q;

endmodule

// ----- src/serial_text_number_formatter_core.sv -----
`timescale 1ns / 1ps
// Serial text and number formatter.
// Input channel (in_valid_i / in_stall_o) carries operation_i, text_byte_i and
// number_i; output channel (out_valid_o / out_stall_i) carries out_byte_o and
// last_o, one ASCII byte a beat, last_o set on the final byte of each item.
// Text: one byte out, a line feed gives CR then LF, NUL gives nothing.
// Decimal: 32 double-dabble steps in the BCD unit, one a cycle, then the
// leading zero digits are skipped one at a time (the last digit is always
// kept), then one byte a cycle while the receiver does not stall.
// Hex: VALUE_WIDTH/4 (rounded up, at most 8) bytes, one a cycle while the
// receiver does not stall. NUL and the unused code give no bytes.
// in_stall_o is high while an item is in work; items do not overlap.
// The output byte sits in a register; a stall from the receiver holds it and
// the sequencer waits before loading the next byte, nothing is lost.
// Reset clears the sequencer and the output valid; the BCD unit is not reset.
module serial_text_number_formatter_core #(
  parameter int VALUE_WIDTH = stnf_pkg::ValueWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  text_byte_i,
  input  logic [31:0] number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import stnf_pkg::*;

  localparam int EffWidth  = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam int HexDigits = (EffWidth + 3) / 4;
  localparam int CntW      = $clog2(NumBits);
  localparam logic [31:0] ValueMask = 32'((64'd1 << EffWidth) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_CR, S_CHAR, S_CONV, S_SKIP, S_DEC, S_HEX
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [DigW-1:0] dig_q;
  logic [7:0]      char_q;
  logic [31:0]     hex_q;
  logic            out_valid_q, out_last_q;
  logic [7:0]      out_byte_q;

  logic            in_acc, out_free, emit;
  logic [31:0]     masked;
  logic [3:0]      cur_digit;
  bcd_ctl_t        bcd_ctl;
  bcd_digits_t     digits;

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = out_free && (state_q == S_CR || state_q == S_CHAR ||
                                  state_q == S_DEC || state_q == S_HEX);
  assign masked    = number_i & ValueMask;
  assign cur_digit = digits[dig_q];

  assign bcd_ctl.load = in_acc && (operation_i == OpDec);
  assign bcd_ctl.step = (state_q == S_CONV);

  stnf_bcd_unit u_bcd (
    .clk_i    (clk_i),
    .ctl_i    (bcd_ctl),
    .value_i  (masked),
    .digits_o (digits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dig_q       <= '0;
      char_q      <= '0;
      hex_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= emit;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (operation_i)
              OpText: begin
                char_q <= text_byte_i;
                if (text_byte_i == CharLf) begin
                  state_q <= S_CR;
                end else if (text_byte_i != CharNul) begin
                  state_q <= S_CHAR;
                end
              end
              OpDec: begin
                cnt_q   <= '0;
                state_q <= S_CONV;
              end
              OpHex: begin
                hex_q   <= masked;
                dig_q   <= DigW'(HexDigits - 1);
                state_q <= S_HEX;
              end
              default: ;
            endcase
          end
        end
        S_CR: begin
          if (out_free) begin
            out_byte_q  <= CharCr;
            out_last_q  <= 1'b0;
            state_q     <= S_CHAR;
          end
        end
        S_CHAR: begin
          if (out_free) begin
            out_byte_q  <= char_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_CONV: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(NumBits - 1)) begin
            dig_q   <= DigW'(DecMax - 1);
            state_q <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (cur_digit == 4'd0 && dig_q != '0) begin
            dig_q <= dig_q - DigW'(1);
          end else begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (out_free) begin
            out_byte_q  <= AsciiZero + {4'b0000, cur_digit};
            out_last_q  <= (dig_q == '0);
            if (dig_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              dig_q <= dig_q - DigW'(1);
            end
          end
        end
        S_HEX: begin
          if (out_free) begin
            out_byte_q  <= nibble_char(hex_q[HexDigits*4-1 -: 4]);
            out_last_q  <= (dig_q == '0);
            hex_q       <= {hex_q[27:0], 4'h0};
            if (dig_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              dig_q <= dig_q - DigW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

// ----- src/stnf_checker.sv -----
`timescale 1ns / 1ps
`include "serial_text_number_formatter_core_defines.svh"

module stnf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  operation_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        last_o
);
  import stnf_pkg::*;

  // held output beat keeps its payload
  `STNF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_byte_o) && $stable(last_o))

  // a number item always keeps the block busy after its accept
  `STNF_ASSERT_NEXT(a_num_busy,
    in_valid_i && !in_stall_o && (operation_i == OpDec || operation_i == OpHex),
    in_stall_o)

  // a beat that is not the last of its run is followed straight away by the next
  `STNF_ASSERT_NEXT(a_run_open, out_valid_o && !out_stall_i && !last_o, out_valid_o)

  // the block only goes busy on an accepted beat
  `STNF_ASSERT_NOW(a_busy_cause, $rose(in_stall_o), $past(in_valid_i))

endmodule

bind serial_text_number_formatter_core stnf_checker u_stnf_checker (.*);

// ----- tb/sv/tb_serial_text_number_formatter_core.sv -----
`timescale 1ns / 1ps

module tb_serial_text_number_formatter_core;
  import stnf_pkg::*;

  localparam int ValueWidth = ValueWidthDef;
  localparam int EffWidth = (ValueWidth > 32) ? 32 : ValueWidth;
  localparam int HexDigits = (EffWidth + 3) / 4;
  localparam logic [31:0] ValueMask =
    (EffWidth >= 32) ? 32'hFFFF_FFFF : ((32'd1 << EffWidth) - 32'd1);
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int TailCycles = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } tx_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [7:0]  text_byte_i;
  logic [31:0] number_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        last_o;

  tx_beat_t expected_beats[$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       stall_left = 0;
  bit       send_idle_en = 1'b1;
  bit       recv_idle_en = 1'b1;

  serial_text_number_formatter_core #(
    .VALUE_WIDTH(ValueWidth)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .text_byte_i (text_byte_i),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void push_beat(input logic [7:0] ch, input logic last);
    tx_beat_t beat;
    beat.ch = ch;
    beat.last = last;
    expected_beats.push_back(beat);
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    string glyphs;
    glyphs = "0123456789ABCDEF";
    return glyphs.getc(int'(nib));
  endfunction

  // Expected byte stream for one accepted item.
  function automatic void predict_format(input logic [1:0] op, input logic [7:0] ch,
                                         input logic [31:0] num);
    logic [31:0] val;
    logic [7:0]  dec_digits[DecMax];
    int          nd;
    int          d;
    val = num & ValueMask;
    case (op)
      OpText: begin
        if (ch == CharLf) begin
          push_beat(CharCr, 1'b0);
          push_beat(CharLf, 1'b1);
        end else if (ch != CharNul) begin
          push_beat(ch, 1'b1);
        end
      end
      OpDec: begin
        nd = 0;
        do begin
          dec_digits[nd] = AsciiZero + 8'(val % 32'd10);
          nd++;
          val = val / 32'd10;
        end while (val != 32'd0 && nd < DecMax);
        for (d = nd - 1; d >= 0; d--) begin
          push_beat(dec_digits[d], d == 0);
        end
      end
      OpHex: begin
        for (d = HexDigits - 1; d >= 0; d--) begin
          push_beat(hex_glyph(4'(val >> (4 * d))), d == 0);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] error: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [31:0] num);
    @(negedge clk_i);
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    text_byte_i = ch;
    number_i = num;
    do @(posedge clk_i); while (in_stall_o);
    predict_format(op, ch, num);
  endtask

  task automatic send_random_item();
    int          pick;
    logic [7:0]  ch;
    logic [31:0] num;
    pick = $urandom_range(0, 99);
    ch = 8'($urandom);
    num = $urandom;
    if (pick < 35) begin
      if ($urandom_range(0, 9) == 0) ch = CharNul;
      else if ($urandom_range(0, 8) == 0) ch = CharLf;
      send_item(OpText, ch, num);
    end else if (pick < 70) begin
      send_item(OpDec, ch, num >> $urandom_range(0, 31));
    end else if (pick < 95) begin
      send_item(OpHex, ch, num);
    end else begin
      send_item(OpUnused, ch, num);
    end
  endtask

  task automatic test_text_bytes();
    send_item(OpText, 8'h41, 32'h0);
    send_item(OpText, CharLf, 32'hFFFF_FFFF);
    send_item(OpText, CharCr, 32'h0);
    send_item(OpText, 8'hFF, 32'h0);
    send_item(OpText, 8'h80, 32'h0);
    send_item(OpText, 8'h7F, 32'h0);
    send_item(OpText, 8'h01, 32'h0);
    send_item(OpText, CharNul, 32'h1234_5678);
  endtask

  task automatic test_decimal_values();
    send_item(OpDec, 8'hFF, 32'd0);
    send_item(OpDec, 8'h00, 32'd9);
    send_item(OpDec, 8'h00, 32'd10);
    send_item(OpDec, 8'h00, 32'd100);
    send_item(OpDec, 8'h00, 32'd999_999_999);
    send_item(OpDec, 8'h00, 32'd1_000_000_000);
    send_item(OpDec, 8'h00, 32'hFFFF_FFFF);
  endtask

  task automatic test_hex_values();
    send_item(OpHex, 8'h00, 32'h0);
    send_item(OpHex, 8'hFF, 32'hFFFF_FFFF);
    send_item(OpHex, 8'h00, 32'h0123_4567);
    send_item(OpHex, 8'h00, 32'h89AB_CDEF);
  endtask

  task automatic test_unused_op();
    send_item(OpUnused, 8'h41, 32'hFFFF_FFFF);
    send_item(OpText, 8'h5A, 32'h0);
    send_item(OpUnused, CharLf, 32'h0);
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_random_item();
  endtask

  // Sender holds off until the output side has drained.
  task automatic test_drain_pause();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (10) send_random_item();
  endtask

  task automatic test_back_to_back();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    repeat (25) send_random_item();
  endtask

  // Receiver stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    tx_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte %h last %b", out_byte_o, last_o));
      end else begin
        want = expected_beats.pop_front();
        if (out_byte_o !== want.ch) begin
          report_mismatch($sformatf("out_byte %h, wanted %h", out_byte_o, want.ch));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %b on byte %h, wanted %b", last_o, out_byte_o,
                                    want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OpText;
    text_byte_i = 8'h00;
    number_i = 32'h0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_text_bytes();
    test_decimal_values();
    test_hex_values();
    test_unused_op();
    test_random_mix(50);
    test_drain_pause();
    test_random_mix(30);
    test_back_to_back();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/stnf_pkg.sv
src/stnf_bcd_unit.sv
src/serial_text_number_formatter_core.sv
src/stnf_checker.sv
tb/sv/tb_serial_text_number_formatter_core.sv
